/* src/crse_pkg.sv */
// ---------------------------------------------------------------------------
// crse_pkg
// Shared widths, codes and types for the spline evaluator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package crse_pkg;

  localparam int PT_W  = 32;  // control point, Q16.16
  localparam int IDX_W = 6;   // point_index field
  localparam int NP_W  = 7;   // num_points register
  localparam int ACC_W = 38;  // Horner accumulator, covers 24 * 2^31

  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_LERP   = 2'd1,
    MODE_CUBIC  = 2'd2
  } mode_t;

  typedef struct packed {
    logic load;
    logic step;
  } horn_ctrl_t;

endpackage

/* src/crse_point_ram.sv */
// ---------------------------------------------------------------------------
// crse_point_ram
// Control point table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module crse_point_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [crse_pkg::PT_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [crse_pkg::PT_W-1:0] rd_data
);
  import crse_pkg::*;

  logic [PT_W-1:0] mem [DEPTH];
  logic [PT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/crse_horner.sv */
// ---------------------------------------------------------------------------
// crse_horner
// Horner step unit: acc <= acc_init on load, acc <= addend + round_half_up(acc * mul / 2^F) on step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module crse_horner #(
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  crse_pkg::horn_ctrl_t              ctrl,
  input  logic signed [crse_pkg::ACC_W-1:0] acc_init,
  input  logic signed [RATIO_FRAC_BITS+1:0] mul,
  input  logic signed [crse_pkg::ACC_W-1:0] addend,
  output logic signed [crse_pkg::ACC_W-1:0] acc
);
  import crse_pkg::*;

  localparam int F  = RATIO_FRAC_BITS;
  localparam int PW = ACC_W + F + 2;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    prod_rnd;
  logic signed [PW-1:0]    prod_sh;

  always_comb begin
    prod     = PW'(acc_r) * PW'(mul);
    prod_rnd = prod + (PW'(1) <<< (F - 1));
    prod_sh  = prod_rnd >>> F;
    acc_nxt  = acc_r;
    if (ctrl.load) begin
      acc_nxt = acc_init;
    end else if (ctrl.step) begin
      acc_nxt = addend + prod_sh[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

/* src/catmull_rom_spline_evaluator.sv */
// ---------------------------------------------------------------------------
// catmull_rom_spline_evaluator
// Uniform Catmull-Rom spline over a table of Q16.16 control points.
// Write words: table updated at the accept edge, no result.
// Evaluate words: section setup, four reads on the single table port, coefficient
//   setup, then dependent multiply/round/add steps on the shared Horner unit (three
//   in cubic mode; the lerp and boundary cases start at the last step). The next
//   word is taken once the result has moved into the output register.
// Reset (rst_n low, synchronous): idle, output empty, num_points = 1;
//   table contents are left as they are.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module catmull_rom_spline_evaluator #(
  parameter int MAX_POINTS      = 64,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,

  // Input channel
  input  logic in_tvalid,
  output logic in_tready,
  // tdata, low bit up: point_index[5:0], point_value[31:0], ratio[F+1:0], zero pad
  input  logic [((crse_pkg::IDX_W + crse_pkg::PT_W + RATIO_FRAC_BITS + 2 + 7) / 8) * 8 - 1:0]
               in_tdata,
  // tuser: opcode (0 write point, 1 evaluate)
  input  logic in_tuser,

  // Result channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // tdata: value[31:0]
  output logic [crse_pkg::PT_W-1:0] out_tdata,
  // tuser: saturated
  output logic                      out_tuser,

  // Configuration: num_points
  input  logic                      cfg_wr_en,
  input  logic [crse_pkg::NP_W-1:0] cfg_wr_data
);
  import crse_pkg::*;

  localparam int F    = RATIO_FRAC_BITS;
  localparam int RW   = F + 2;                     // ratio width
  localparam int AW   = $clog2(MAX_POINTS);        // table address
  localparam int CW   = (AW + 1 > NP_W) ? AW + 1 : NP_W;
  localparam int TW   = F + 1 + NP_W;              // section product
  localparam int SW   = 9;                         // section index math
  localparam int VOFF = IDX_W;
  localparam int ROFF = IDX_W + PT_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SECT = 6'b000010,
    S_READ = 6'b000100,
    S_COEF = 6'b001000,
    S_HORN = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // ------------------------------------------------------------------------
  // Input word unpack
  // ------------------------------------------------------------------------
  logic [IDX_W-1:0]     in_idx;
  logic [PT_W-1:0]      in_val;
  logic signed [RW-1:0] in_ratio;
  logic                 in_acc;
  logic                 idx_ok;

  assign in_idx   = in_tdata[IDX_W-1:0];
  assign in_val   = in_tdata[VOFF +: PT_W];
  assign in_ratio = signed'(in_tdata[ROFF +: RW]);
  assign in_acc   = in_tvalid && in_tready;
  assign idx_ok   = CW'(in_idx) < CW'(MAX_POINTS);

  // ------------------------------------------------------------------------
  // num_points register, clamped to 1..MAX_POINTS on write
  // ------------------------------------------------------------------------
  logic [NP_W-1:0] n_r, n_nxt;

  always_comb begin
    n_nxt = n_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        n_nxt = NP_W'(1);
      end else if (CW'(cfg_wr_data) > CW'(MAX_POINTS)) begin
        n_nxt = NP_W'(MAX_POINTS);
      end else begin
        n_nxt = cfg_wr_data;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Point table
  // ------------------------------------------------------------------------
  logic            tbl_we;
  logic            tbl_re;
  logic [AW-1:0]   tbl_raddr;
  logic [PT_W-1:0] tbl_rdata;

  assign tbl_we = in_acc && (in_tuser == OPC_WRITE) && idx_ok;

  crse_point_ram #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (AW'(in_idx)),
    .wr_data (in_val),
    .rd_en   (tbl_re),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  // ------------------------------------------------------------------------
  // Section setup: mode, four read addresses, Horner multiplier
  // ------------------------------------------------------------------------
  logic signed [RW-1:0] ratio_r;
  mode_t                mode_r, mode_nxt;
  logic [AW-1:0]        addr_r [4];
  logic [AW-1:0]        addr_nxt [4];
  logic signed [RW-1:0] mul_r, mul_nxt;

  logic [TW-1:0]        total;
  logic [SW-1:0]        sec, nm1, nm2, sp2;
  logic                 past_end;

  always_comb begin
    total    = TW'(ratio_r[F:0]) * TW'(n_r - NP_W'(1));
    sec      = SW'(total[TW-1:F]);
    nm1      = SW'(n_r) - SW'(1);
    nm2      = SW'(n_r) - SW'(2);
    sp2      = sec + SW'(2);
    past_end = sec > nm2;

    mode_nxt = MODE_CUBIC;
    mul_nxt  = signed'({2'b00, total[F-1:0]});
    addr_nxt[0] = (sec == '0) ? '0 : AW'(sec - SW'(1));
    addr_nxt[1] = AW'(sec);
    addr_nxt[2] = AW'(sec + SW'(1));
    addr_nxt[3] = (sp2 > nm1) ? AW'(nm1) : AW'(sp2);

    if (n_r == NP_W'(1) || (n_r != NP_W'(2) && ratio_r[RW-1])) begin
      // single point, or negative ratio outside the two-point case: first point
      mode_nxt = MODE_DIRECT;
      for (int k = 0; k < 4; k++) addr_nxt[k] = '0;
    end else if (n_r == NP_W'(2)) begin
      // p1 slot = point 0, p2 slot = point 1, raw ratio as factor
      mode_nxt    = MODE_LERP;
      mul_nxt     = ratio_r;
      addr_nxt[0] = '0;
      addr_nxt[1] = '0;
      addr_nxt[2] = AW'(1);
      addr_nxt[3] = AW'(1);
    end else if (past_end) begin
      mode_nxt = MODE_DIRECT;
      for (int k = 0; k < 4; k++) addr_nxt[k] = AW'(nm1);
    end
  end

  // ------------------------------------------------------------------------
  // Table reads: slot k issued at read count k, captured at read count k + 1.
  // Slot 3 is used straight from the RAM output during coefficient setup.
  // ------------------------------------------------------------------------
  logic [1:0]             rd_cnt_r, rd_cnt_nxt;
  logic signed [PT_W-1:0] p_r [3];

  assign tbl_re    = (state_r == S_READ);
  assign tbl_raddr = addr_r[rd_cnt_r];

  // ------------------------------------------------------------------------
  // Coefficients (Horner form, scaled by 2 in cubic mode)
  // ------------------------------------------------------------------------
  logic signed [ACC_W-1:0] pe0, pe1, pe2, pe3;
  logic signed [ACC_W-1:0] coef_a, coef_b, coef_c, coef_d;
  logic signed [ACC_W-1:0] a_r, b_r, c_r;

  always_comb begin
    pe0 = ACC_W'(p_r[0]);
    pe1 = ACC_W'(p_r[1]);
    pe2 = ACC_W'(p_r[2]);
    pe3 = ACC_W'(signed'(tbl_rdata));
    coef_a = pe1 <<< 1;
    coef_b = pe2 - pe0;
    coef_c = (pe0 <<< 1) - ((pe1 <<< 2) + pe1) + (pe2 <<< 2) - pe3;
    coef_d = -pe0 + ((pe1 <<< 1) + pe1) - ((pe2 <<< 1) + pe2) + pe3;
    if (mode_r == MODE_LERP) begin
      coef_a = pe1;
      coef_d = pe2 - pe1;
    end
  end

  // ------------------------------------------------------------------------
  // Horner unit control
  // ------------------------------------------------------------------------
  logic [1:0]              hcnt_r, hcnt_nxt;
  horn_ctrl_t              hctl;
  logic signed [ACC_W-1:0] h_addend;
  logic signed [ACC_W-1:0] h_acc;

  assign hctl.load = (state_r == S_COEF);
  assign hctl.step = (state_r == S_HORN);

  always_comb begin
    case (hcnt_r)
      2'd0:    h_addend = c_r;
      2'd1:    h_addend = b_r;
      default: h_addend = a_r;
    endcase
  end

  crse_horner #(
    .RATIO_FRAC_BITS (F)
  ) u_horner (
    .clk      (clk),
    .ctrl     (hctl),
    .acc_init (coef_d),
    .mul      (mul_r),
    .addend   (h_addend),
    .acc      (h_acc)
  );

  // ------------------------------------------------------------------------
  // Final scaling and saturation
  // ------------------------------------------------------------------------
  logic signed [ACC_W-1:0] fin;
  logic                    fin_ovf;
  logic [PT_W-1:0]         fin_val;
  logic                    fin_sat;

  always_comb begin
    fin = h_acc;
    if (mode_r == MODE_CUBIC) begin
      fin = (h_acc + ACC_W'(1)) >>> 1;
    end
    fin_ovf = !((&fin[ACC_W-1:PT_W-1]) || !(|fin[ACC_W-1:PT_W-1]));
    if (mode_r == MODE_DIRECT) begin
      fin_val = p_r[1];
      fin_sat = 1'b0;
    end else if (fin_ovf) begin
      fin_val = fin[ACC_W-1] ? {1'b1, {(PT_W-1){1'b0}}} : {1'b0, {(PT_W-1){1'b1}}};
      fin_sat = 1'b1;
    end else begin
      fin_val = fin[PT_W-1:0];
      fin_sat = 1'b0;
    end
  end

  // ------------------------------------------------------------------------
  // Output register: holds a finished word while the core starts the next
  // ------------------------------------------------------------------------
  logic            out_valid_r, out_valid_nxt;
  logic [PT_W-1:0] out_val_r;
  logic            out_sat_r;
  logic            out_load;

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_sat_r;

  // ------------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    hcnt_nxt   = hcnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == OPC_EVAL) begin
          state_nxt = S_SECT;
        end
      end
      S_SECT: begin
        state_nxt  = S_READ;
        rd_cnt_nxt = '0;
      end
      S_READ: begin
        rd_cnt_nxt = rd_cnt_r + 2'd1;
        if (rd_cnt_r == 2'd3) begin
          state_nxt = S_COEF;
        end
      end
      S_COEF: begin
        state_nxt = S_HORN;
        hcnt_nxt  = (mode_r == MODE_CUBIC) ? 2'd0 : 2'd2;
      end
      S_HORN: begin
        hcnt_nxt = hcnt_r + 2'd1;
        if (hcnt_r == 2'd2) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      hcnt_r      <= '0;
      out_valid_r <= 1'b0;
      n_r         <= NP_W'(1);
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      hcnt_r      <= hcnt_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == OPC_EVAL) begin
      ratio_r <= in_ratio;
    end
    if (state_r == S_SECT) begin
      mode_r <= mode_nxt;
      mul_r  <= mul_nxt;
      for (int k = 0; k < 4; k++) addr_r[k] <= addr_nxt[k];
    end
    if (state_r == S_READ && rd_cnt_r != 2'd0) begin
      p_r[rd_cnt_r - 2'd1] <= signed'(tbl_rdata);
    end
    if (state_r == S_COEF) begin
      a_r <= coef_a;
      b_r <= coef_b;
      c_r <= coef_c;
    end
    if (out_load) begin
      out_val_r <= fin_val;
      out_sat_r <= fin_sat;
    end
  end

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OPC_WRITE |=> state_r == S_IDLE)
    else $error("write word left idle");

  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OPC_EVAL |=> state_r == S_SECT)
    else $error("evaluate word did not start setup");

  a_four_reads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SECT |=> ##3 state_r == S_READ ##1 state_r == S_COEF)
    else $error("read phase not four cycles");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_tvalid && !out_tready |=> state_r == S_DONE)
    else $error("finished word dropped while output stalled");

endmodule
